/* rtl/float_truncate_bit_packer_macros.svh */
// Assertion macros for the float truncation bit packer.
// Used by float_truncate_bit_packer.sv; expects clk and rst_n in scope.
`ifndef FLOAT_TRUNCATE_BIT_PACKER_MACROS_SVH
`define FLOAT_TRUNCATE_BIT_PACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define FTBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTBP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTBP_ASSERT(label, prop, msg)
`define FTBP_ASSERT_RST(label, prop, msg)
`endif
`endif

/* rtl/ftbp_pkg.sv */
// Shared types and constants for the float truncation bit packer.
// No dependencies; used by float_truncate_bit_packer.sv.
`default_nettype none

package ftbp_pkg;

  typedef struct packed {
    logic [31:0] value;
    logic        first;
    logic        last;
    logic [24:0] count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic        run_end;
    logic        block_end;
  } out_item_t;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_KEPT_BITS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DROP_SIGN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PACK_ENABLE = 2'd2;

  localparam logic [4:0]  KEPT_BITS_RST = 5'd16;
  localparam logic [4:0]  KEPT_BITS_MIN = 5'd2;
  localparam logic [11:0] LIMIT_HIGH    = 12'h7f7;
  localparam logic [31:0] LIMIT_LOW     = 32'h000f_ffff;
  localparam logic [31:0] MAG_MASK      = 32'h7fff_ffff;
  localparam logic [5:0]  WORD_BITS     = 6'd32;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;
  localparam int unsigned MaxOut = 3;

endpackage

`default_nettype wire

/* rtl/float_truncate_bit_packer.sv */
// Float truncation bit packer top level: input register, pack logic, result queue.
// Depends on ftbp_pkg and float_truncate_bit_packer_macros.svh.
//
// Takes one float word per item. An item whose results fit the result queue enters
// every cycle and passes the input register and the result queue. It yields zero
// to three words (header on first, data or raw word, flush on last in pack mode),
// and the single output port drains one word per cycle while out_ready is high, so
// throughput is one item per cycle while items give at most one word, and the
// output port sets the rate otherwise. The four-entry queue parts the input stage
// from the output; the input stage moves on when at least three entries are free.
`default_nettype none
`include "float_truncate_bit_packer_macros.svh"

module float_truncate_bit_packer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire ftbp_pkg::in_item_t                in_data,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      ftbp_pkg::out_item_t               out_data,
  input  wire logic                              cfg_we,
  input  wire logic [ftbp_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [ftbp_pkg::CfgDataW-1:0]     cfg_data
);

  // configuration
  logic [4:0] kept_bits_r;
  logic       drop_sign_r;
  logic       pack_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_bits_r   <= ftbp_pkg::KEPT_BITS_RST;
      drop_sign_r   <= 1'b0;
      pack_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ftbp_pkg::CFG_KEPT_BITS:   kept_bits_r   <= cfg_data;
        ftbp_pkg::CFG_DROP_SIGN:   drop_sign_r   <= cfg_data[0];
        ftbp_pkg::CFG_PACK_ENABLE: pack_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid_r;
  ftbp_pkg::in_item_t s1_item_r;
  logic               s1_adv;

  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // pack logic
  logic [31:0] partial_word_r, partial_word_nxt;
  logic [5:0]  free_bits_r, free_bits_nxt;

  logic [4:0]  kb;
  logic [5:0]  sh, len, f, d, nf;
  logic [31:0] half, limit, mask, field, pw_or, data_word;
  logic        emit_data;
  logic [31:0] pw_base;

  always_comb begin
    kb    = (kept_bits_r < ftbp_pkg::KEPT_BITS_MIN) ? ftbp_pkg::KEPT_BITS_MIN : kept_bits_r;
    sh    = ftbp_pkg::WORD_BITS - {1'b0, kb};
    half  = 32'd1 << (sh - 6'd1);
    limit = {ftbp_pkg::LIMIT_HIGH, 20'd0} | (ftbp_pkg::LIMIT_LOW ^ half);
    mask  = 32'hffff_ffff >> (sh + {5'd0, drop_sign_r});
    len   = {1'b0, kb} - {5'd0, drop_sign_r};

    // a first item starts from an empty word
    pw_base = s1_item_r.first ? 32'd0 : partial_word_r;
    f       = s1_item_r.first ? ftbp_pkg::WORD_BITS : free_bits_r;
    if (f == 6'd0 || f > ftbp_pkg::WORD_BITS) f = ftbp_pkg::WORD_BITS;

    if ((s1_item_r.value & ftbp_pkg::MAG_MASK) > limit) field = s1_item_r.value >> sh;
    else                                                 field = (s1_item_r.value + half) >> sh;
    field = field & mask;

    d                = len - f;
    nf               = ftbp_pkg::WORD_BITS - d;
    emit_data        = 1'b0;
    data_word        = 32'd0;
    pw_or            = 32'd0;
    partial_word_nxt = pw_base;
    free_bits_nxt    = f;

    if (f > len) begin
      free_bits_nxt    = f - len;
      partial_word_nxt = pw_base | (field << free_bits_nxt);
    end else if (f == len) begin
      emit_data        = 1'b1;
      data_word        = pw_base | field;
      partial_word_nxt = 32'd0;
      free_bits_nxt    = ftbp_pkg::WORD_BITS;
    end else begin
      // split the field: high part closes this word, low part opens the next
      emit_data        = 1'b1;
      data_word        = pw_base | (field >> d);
      free_bits_nxt    = nf;
      partial_word_nxt = field << nf;
    end
    pw_or = partial_word_nxt;

    if (s1_item_r.last) begin
      partial_word_nxt = 32'd0;
      free_bits_nxt    = ftbp_pkg::WORD_BITS;
    end

    // raw mode leaves the packing state alone apart from the header clear
    if (!pack_enable_r) begin
      partial_word_nxt = pw_base;
      free_bits_nxt    = f;
    end
  end

  // gather this item's results in order
  ftbp_pkg::out_item_t slot [ftbp_pkg::MaxOut];
  logic [1:0]          push_n;

  always_comb begin
    for (int i = 0; i < ftbp_pkg::MaxOut; i++) slot[i] = '0;
    push_n = 2'd0;
    if (s1_item_r.first) begin
      slot[push_n].word = {s1_item_r.count, 1'b0, kb, drop_sign_r};
      push_n = push_n + 2'd1;
    end
    if (!pack_enable_r) begin
      slot[push_n].word      = s1_item_r.value;
      slot[push_n].block_end = s1_item_r.last;
      push_n = push_n + 2'd1;
    end else begin
      if (emit_data) begin
        slot[push_n].word = data_word;
        push_n = push_n + 2'd1;
      end
      if (s1_item_r.last) begin
        slot[push_n].word      = pw_or;
        slot[push_n].block_end = 1'b1;
        push_n = push_n + 2'd1;
      end
    end
    if (push_n != 2'd0) slot[push_n - 2'd1].run_end = 1'b1;
  end

  // result queue
  ftbp_pkg::out_item_t             q_mem [ftbp_pkg::QDepth];
  logic [ftbp_pkg::QPtrW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ftbp_pkg::QCntW-1:0]      q_cnt_r, cnt_after_pop;
  logic                            pop;

  assign out_valid     = (q_cnt_r != '0);
  assign out_data      = q_mem[rd_ptr_r];
  assign pop           = out_valid && out_ready;
  assign cnt_after_pop = q_cnt_r - {{(ftbp_pkg::QCntW-1){1'b0}}, pop};
  assign s1_adv        = s1_valid_r && (cnt_after_pop <= ftbp_pkg::QCntW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_word_r <= 32'd0;
      free_bits_r    <= ftbp_pkg::WORD_BITS;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      q_cnt_r        <= '0;
    end else begin
      if (s1_adv) begin
        partial_word_r <= partial_word_nxt;
        free_bits_r    <= free_bits_nxt;
        wr_ptr_r       <= wr_ptr_r + ftbp_pkg::QPtrW'(push_n);
      end
      if (pop) rd_ptr_r <= rd_ptr_r + ftbp_pkg::QPtrW'(1);
      q_cnt_r <= cnt_after_pop + (s1_adv ? ftbp_pkg::QCntW'(push_n) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < ftbp_pkg::MaxOut; i++) begin
        if (2'(i) < push_n) q_mem[wr_ptr_r + ftbp_pkg::QPtrW'(i)] <= slot[i];
      end
    end
  end

  `FTBP_ASSERT(a_q_no_overflow, q_cnt_r <= ftbp_pkg::QCntW'(ftbp_pkg::QDepth), "result queue overflow")
  `FTBP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `FTBP_ASSERT(a_free_bits_range, free_bits_r != 6'd0 && free_bits_r <= ftbp_pkg::WORD_BITS, "free bit count out of range")
  `FTBP_ASSERT(a_pop_advances, pop |=> rd_ptr_r == $past(rd_ptr_r) + ftbp_pkg::QPtrW'(1), "read pointer did not advance")
  `FTBP_ASSERT_RST(a_reset_empty, !rst_n |=> q_cnt_r == '0 && !s1_valid_r, "queue not empty after reset")

endmodule

`default_nettype wire
